// ===== src/npdt_pkg.sv =====
// Shared types and constants for the name-to-page directory table.
package npdt_pkg;

	localparam int KEY_W           = 248;
	localparam int PAGE_W          = 32;
	localparam int CMD_W           = 2;
	localparam int STATUS_W        = 2;
	localparam int USED_W          = 7;
	localparam int DEF_MAX_ENTRIES = 64;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_UPDATE = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_LOOKUP = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_ABSENT  = 2'd1,
		ST_PRESENT = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load_in;
		logic scan_en;
		logic exec;
		logic move;
		logic fetch;
		logic load_out;
	} ctrl_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic scan_end;
		logic found;
		cmd_t cmd;
	} dp_status_t;

endpackage

// ===== src/name_to_page_directory_table_unit.sv =====
// Top level of the name-to-page directory table: stream ports, controller and datapath.
//
// Holds up to MAX_ENTRIES records, each a 248-bit name key and a 32-bit page number, and
// takes one command word at a time. The key RAM is scanned one record per cycle, and a
// command passes through accept, a scan of the n records held (a scan stops in the cycle
// that compares the matching record), execute, a record move (successful delete) or page
// fetch (successful lookup), and a result step that waits while the output register
// still holds an untaken word. The next word is accepted as soon as the result is
// registered, while that result may still wait on m_tready. Stores need no clearing after
// reset: only the first n records are ever read.
module name_to_page_directory_table_unit
	import npdt_pkg::*;
	#(
		parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
	)
	(
		input  logic         clk,
		input  logic         arst_n,
		input  logic         s_tvalid,
		output logic         s_tready,
		// key_word0, key_word1, key_word2, key_word3, new_page
		input  logic [279:0] s_tdata,
		// command
		input  logic [7:0]   s_tuser,
		output logic         m_tvalid,
		input  logic         m_tready,
		// status, found_page, entries_used, zero fill
		output logic [47:0]  m_tdata
	);

	ctrl_cmd_t           ctl;
	dp_status_t          sts;
	logic [STATUS_W-1:0] out_status;
	logic [PAGE_W-1:0]   out_page;
	logic [USED_W-1:0]   out_used;

	assign m_tdata = {7'd0, out_used, out_page, out_status};

	npdt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	npdt_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.in_cmd     (s_tuser[CMD_W-1:0]),
		.in_data    (s_tdata[KEY_W+PAGE_W-1:0]),
		.sts        (sts),
		.out_status (out_status),
		.out_page   (out_page),
		.out_used   (out_used)
	);

endmodule

// ===== src/npdt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module npdt_ram
	#(
		parameter int WIDTH = 32,
		parameter int DEPTH = 64
	)
	(
		input  logic                     clk,
		input  logic                     we,
		input  logic [$clog2(DEPTH)-1:0] waddr,
		input  logic [WIDTH-1:0]         wdata,
		input  logic [$clog2(DEPTH)-1:0] raddr,
		output logic [WIDTH-1:0]         rdata
	);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/npdt_datapath.sv =====
// Datapath: operand registers, record count, key scan, record stores and result register.
module npdt_datapath
	import npdt_pkg::*;
	#(
		parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
	)
	(
		input  logic                      clk,
		input  logic                      arst_n,
		input  ctrl_cmd_t                 ctl,
		input  logic [CMD_W-1:0]          in_cmd,
		input  logic [KEY_W+PAGE_W-1:0]   in_data,
		output dp_status_t                sts,
		output logic [STATUS_W-1:0]       out_status,
		output logic [PAGE_W-1:0]         out_page,
		output logic [USED_W-1:0]         out_used
	);

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	cmd_t                cmd_q;
	logic [KEY_W-1:0]    key_q;
	logic [PAGE_W-1:0]   page_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       iss_q;
	logic                chk_vld_s1;
	logic [AW-1:0]       chk_idx_s1;
	logic                found_q;
	logic [AW-1:0]       slot_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [PAGE_W-1:0]   res_page_q;

	logic                issue;
	logic                hit;
	logic                full;
	logic [CW-1:0]       last_full;
	logic [AW-1:0]       last_idx;
	logic [CW+USED_W-1:0] count_ext;

	logic                key_we;
	logic [AW-1:0]       key_waddr;
	logic [KEY_W-1:0]    key_wdata;
	logic [KEY_W-1:0]    key_rdata;
	logic                page_we;
	logic [AW-1:0]       page_waddr;
	logic [PAGE_W-1:0]   page_wdata;
	logic [PAGE_W-1:0]   page_rdata;
	logic [AW-1:0]       raddr;

	assign full      = (count_q >= CW'(MAX_ENTRIES));
	assign last_full = count_q - CW'(1);
	assign last_idx  = last_full[AW-1:0];
	assign issue     = ctl.scan_en && (iss_q < count_q) && !hit;
	assign hit       = ctl.scan_en && chk_vld_s1 && (key_rdata == key_q);

	// End the scan on a match or once the last record is under comparison
	assign sts.scan_end = hit || !(iss_q < count_q);
	assign sts.found    = found_q;
	assign sts.cmd      = cmd_q;

	// Select the shared read address
	always_comb begin
		if (ctl.scan_en) begin
			raddr = iss_q[AW-1:0];
		end else if (cmd_q == CMD_DELETE) begin
			raddr = last_idx;
		end else begin
			raddr = slot_q;
		end
	end

	// Steer the write ports
	always_comb begin
		key_we     = 1'b0;
		key_waddr  = slot_q;
		key_wdata  = key_rdata;
		page_we    = 1'b0;
		page_waddr = slot_q;
		page_wdata = page_rdata;
		if (ctl.exec) begin
			if (cmd_q == CMD_INSERT && !found_q && !full) begin
				key_we     = 1'b1;
				key_waddr  = count_q[AW-1:0];
				key_wdata  = key_q;
				page_we    = 1'b1;
				page_waddr = count_q[AW-1:0];
				page_wdata = page_q;
			end else if (cmd_q == CMD_UPDATE && found_q) begin
				page_we    = 1'b1;
				page_wdata = page_q;
			end
		end else if (ctl.move) begin
			key_we  = 1'b1;
			page_we = 1'b1;
		end
	end

	// Latch operands
	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			key_q  <= in_data[KEY_W-1:0];
			page_q <= in_data[KEY_W+PAGE_W-1:KEY_W];
		end
	end

	// Control registers: command, count, scan pointer and hit flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q      <= CMD_INSERT;
			count_q    <= '0;
			iss_q      <= '0;
			chk_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			if (ctl.load_in) begin
				cmd_q      <= cmd_t'(in_cmd);
				iss_q      <= '0;
				chk_vld_s1 <= 1'b0;
				found_q    <= 1'b0;
			end else if (ctl.scan_en) begin
				if (issue) begin
					iss_q <= iss_q + CW'(1);
				end
				chk_vld_s1 <= issue;
				if (hit) begin
					found_q <= 1'b1;
				end
			end
			if (ctl.exec && cmd_q == CMD_INSERT && !found_q && !full) begin
				count_q <= count_q + CW'(1);
			end else if (ctl.move) begin
				count_q <= last_full;
			end
		end
	end

	// Track the index under comparison and the matched slot
	always_ff @(posedge clk) begin
		if (issue) begin
			chk_idx_s1 <= iss_q[AW-1:0];
		end
		if (hit) begin
			slot_q <= chk_idx_s1;
		end
	end

	// Form the result
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			res_page_q <= '0;
			unique case (cmd_q)
				CMD_INSERT: begin
					if (found_q) begin
						res_status_q <= ST_PRESENT;
					end else if (full) begin
						res_status_q <= ST_FULL;
					end else begin
						res_status_q <= ST_OK;
					end
				end
				CMD_UPDATE, CMD_DELETE, CMD_LOOKUP: begin
					res_status_q <= found_q ? ST_OK : ST_ABSENT;
				end
				default: res_status_q <= ST_ABSENT;
			endcase
		end
		if (ctl.fetch) begin
			res_page_q <= page_rdata;
		end
	end

	assign count_ext = {{USED_W{1'b0}}, count_q};

	// Output word register
	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			out_status <= res_status_q;
			out_page   <= res_page_q;
			out_used   <= count_ext[USED_W-1:0];
		end
	end

	npdt_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ENTRIES)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (key_wdata),
		.raddr (raddr),
		.rdata (key_rdata)
	);

	npdt_ram #(.WIDTH(PAGE_W), .DEPTH(MAX_ENTRIES)) u_page_ram (
		.clk   (clk),
		.we    (page_we),
		.waddr (page_waddr),
		.wdata (page_wdata),
		.raddr (raddr),
		.rdata (page_rdata)
	);

endmodule

// ===== src/npdt_ctrl.sv =====
// Controller: sequences accept, key scan, execute, record move or page fetch, and result.
module npdt_ctrl
	import npdt_pkg::*;
	(
		input  logic       clk,
		input  logic       arst_n,
		input  logic       s_tvalid,
		output logic       s_tready,
		output logic       m_tvalid,
		input  logic       m_tready,
		input  dp_status_t sts,
		output ctrl_cmd_t  ctl
	);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SCAN  = 6'b000010,
		S_EXEC  = 6'b000100,
		S_MOVE  = 6'b001000,
		S_FETCH = 6'b010000,
		S_RESP  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_vld_q;
	logic   out_free;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_vld_q;
	assign out_free = !out_vld_q || m_tready;

	// Decode commands and next state
	always_comb begin
		ctl     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					ctl.load_in = 1'b1;
					state_d     = S_SCAN;
				end
			end
			S_SCAN: begin
				ctl.scan_en = 1'b1;
				if (sts.scan_end) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				ctl.exec = 1'b1;
				if (sts.found && sts.cmd == CMD_DELETE) begin
					state_d = S_MOVE;
				end else if (sts.found && sts.cmd == CMD_LOOKUP) begin
					state_d = S_FETCH;
				end else begin
					state_d = S_RESP;
				end
			end
			S_MOVE: begin
				ctl.move = 1'b1;
				state_d  = S_RESP;
			end
			S_FETCH: begin
				ctl.fetch = 1'b1;
				state_d   = S_RESP;
			end
			S_RESP: begin
				if (out_free) begin
					ctl.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Hold state and the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load_out) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule

// ===== tb/name_to_page_directory_table_unit_tb.sv =====
// Self-checking testbench for the name-to-page directory table unit.
module name_to_page_directory_table_unit_tb;
	import npdt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH = DEF_MAX_ENTRIES;
	localparam int POOL_SIZE   = 80;
	localparam int IDLE_PCT    = 13;
	localparam int SETTLE_CYC  = 100;

	typedef struct {
		status_t           status;
		logic [PAGE_W-1:0] page;
		logic [USED_W-1:0] used;
	} dir_reply_t;

	logic          clk;
	logic          arst_n;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [279:0]  s_tdata  = '0;
	logic [7:0]    s_tuser  = '0;
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [47:0]   m_tdata;

	// Shadow copy of the directory contents
	logic [KEY_W-1:0]  dir_keys [TABLE_DEPTH];
	logic [PAGE_W-1:0] dir_pages[TABLE_DEPTH];
	int                dir_count;

	dir_reply_t        expected_replies[$];
	logic [KEY_W-1:0]  name_pool[POOL_SIZE];
	bit                idle_on;
	int                mismatch_count;
	int                words_sent;
	int                status_seen[4];

	name_to_page_directory_table_unit #(
		.MAX_ENTRIES(TABLE_DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Generous overall limit
	initial begin
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// Random stalls on the result side
	always @(negedge clk) begin
		m_tready <= idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
	end

	// Work out the reply to one command and update the shadow directory
	function automatic void predict_directory(cmd_t cmd, logic [KEY_W-1:0] key,
			logic [PAGE_W-1:0] page);
		int         slot;
		dir_reply_t r;
		slot     = -1;
		r.status = ST_OK;
		r.page   = '0;
		for (int i = 0; i < dir_count; i++) begin
			if (slot < 0 && dir_keys[i] == key)
				slot = i;
		end
		if (cmd == CMD_INSERT) begin
			if (slot >= 0) begin
				r.status = ST_PRESENT;
			end else if (dir_count >= TABLE_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				dir_keys[dir_count]  = key;
				dir_pages[dir_count] = page;
				dir_count++;
			end
		end else if (slot < 0) begin
			r.status = ST_ABSENT;
		end else begin
			case (cmd)
				CMD_UPDATE: begin
					dir_pages[slot] = page;
				end
				CMD_DELETE: begin
					// move the last record into the freed slot
					dir_keys[slot]  = dir_keys[dir_count-1];
					dir_pages[slot] = dir_pages[dir_count-1];
					dir_count--;
				end
				default: begin
					r.page = dir_pages[slot];
				end
			endcase
		end
		r.used = dir_count[USED_W-1:0];
		status_seen[r.status]++;
		expected_replies.push_back(r);
	endfunction

	// Compare each reply word with the oldest expectation
	always @(posedge clk) begin
		dir_reply_t e;
		if (m_tvalid && m_tready) begin
			if (expected_replies.size() == 0) begin
				$display("%0t: reply word with none expected, actual %h", $time, m_tdata);
				mismatch_count++;
			end else begin
				e = expected_replies.pop_front();
				if (m_tdata[1:0] !== e.status) begin
					$display("%0t: status expected %0d actual %0d", $time, e.status,
						m_tdata[1:0]);
					mismatch_count++;
				end
				if (m_tdata[33:2] !== e.page) begin
					$display("%0t: found_page expected %h actual %h", $time, e.page,
						m_tdata[33:2]);
					mismatch_count++;
				end
				if (m_tdata[40:34] !== e.used) begin
					$display("%0t: entries_used expected %0d actual %0d", $time, e.used,
						m_tdata[40:34]);
					mismatch_count++;
				end
			end
		end
	end

	function automatic logic [KEY_W-1:0] rand_key();
		logic [255:0] t;
		for (int i = 0; i < 8; i++)
			t[i*32 +: 32] = $urandom;
		return t[KEY_W-1:0];
	endfunction

	// Printable name, zero padded; sometimes with a byte after an embedded zero
	function automatic logic [KEY_W-1:0] text_key();
		logic [KEY_W-1:0] k;
		int               len;
		int               gap;
		k   = '0;
		len = $urandom_range(31, 4);
		for (int i = 0; i < len; i++)
			k[i*8 +: 8] = 8'($urandom_range(126, 33));
		if (len < 29 && $urandom_range(3) == 0) begin
			gap = $urandom_range(30, len + 1);
			k[gap*8 +: 8] = 8'($urandom_range(255, 1));
		end
		return k;
	endfunction

	function automatic logic [PAGE_W-1:0] rand_page();
		case ($urandom_range(9))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Present one command word and hold it until taken
	task automatic send_word(cmd_t cmd, logic [KEY_W-1:0] key, logic [PAGE_W-1:0] page);
		if (idle_on) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {page, key};
		s_tuser  <= {6'd0, cmd};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_directory(cmd, key, page);
		words_sent++;
		@(negedge clk);
	endtask

	// Hold off the sender until every reply is back
	task automatic wait_replies_drained();
		s_tvalid <= 1'b0;
		wait (expected_replies.size() == 0);
		@(negedge clk);
	endtask

	// Weighted command mix over the name pool, with some fresh names as noise
	task automatic run_mix(int count, int ins_w, int upd_w, int del_w, int drain_every);
		cmd_t             cmd;
		logic [KEY_W-1:0] key;
		int               r;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			if (r < ins_w)
				cmd = CMD_INSERT;
			else if (r < ins_w + upd_w)
				cmd = CMD_UPDATE;
			else if (r < ins_w + upd_w + del_w)
				cmd = CMD_DELETE;
			else
				cmd = CMD_LOOKUP;
			if ($urandom_range(9) == 0)
				key = rand_key();
			else
				key = name_pool[$urandom_range(POOL_SIZE-1)];
			send_word(cmd, key, rand_page());
			if (drain_every > 0 && (n % drain_every) == drain_every - 1)
				wait_replies_drained();
		end
	endtask

	// Extreme keys and pages, absent names, duplicates, embedded zeros, record move
	task automatic test_directed();
		logic [KEY_W-1:0] k_zero;
		logic [KEY_W-1:0] k_ones;
		logic [KEY_W-1:0] k_a;
		logic [KEY_W-1:0] k_b;
		k_zero = '0;
		k_ones = '1;
		k_a    = {224'd0, "cat"};
		k_b    = k_a;
		k_b[80 +: 8] = 8'h5a;
		send_word(CMD_LOOKUP, k_zero, 32'h0);
		send_word(CMD_UPDATE, k_ones, 32'h1234_5678);
		send_word(CMD_DELETE, k_a, 32'h0);
		send_word(CMD_INSERT, k_zero, 32'h8000_0000);
		send_word(CMD_INSERT, k_ones, 32'h7fff_ffff);
		send_word(CMD_INSERT, k_zero, 32'hffff_ffff);
		send_word(CMD_LOOKUP, k_zero, 32'hffff_ffff);
		send_word(CMD_LOOKUP, k_ones, 32'h0);
		send_word(CMD_UPDATE, k_zero, 32'hffff_ffff);
		send_word(CMD_LOOKUP, k_zero, 32'h0);
		send_word(CMD_INSERT, k_a, 32'h0000_0001);
		send_word(CMD_LOOKUP, k_b, 32'h0);
		send_word(CMD_INSERT, k_b, 32'h0000_0002);
		send_word(CMD_LOOKUP, k_b, 32'h0);
		send_word(CMD_DELETE, k_zero, 32'h0);
		send_word(CMD_LOOKUP, k_b, 32'h0);
		send_word(CMD_LOOKUP, k_a, 32'h0);
		send_word(CMD_DELETE, k_b, 32'h0);
		send_word(CMD_DELETE, k_ones, 32'h0);
		send_word(CMD_DELETE, k_a, 32'h0);
		send_word(CMD_LOOKUP, k_a, 32'h0);
		wait_replies_drained();
	endtask

	// Fill to capacity, overflow, duplicate while full, then empty again
	task automatic test_fill_and_full();
		for (int i = 0; i < TABLE_DEPTH; i++)
			send_word(CMD_INSERT, name_pool[i], rand_page());
		send_word(CMD_INSERT, name_pool[TABLE_DEPTH], rand_page());
		send_word(CMD_INSERT, name_pool[5], rand_page());
		send_word(CMD_LOOKUP, name_pool[TABLE_DEPTH-1], 32'h0);
		send_word(CMD_DELETE, name_pool[7], 32'h0);
		send_word(CMD_LOOKUP, name_pool[TABLE_DEPTH-1], 32'h0);
		send_word(CMD_INSERT, name_pool[TABLE_DEPTH], rand_page());
		send_word(CMD_INSERT, name_pool[TABLE_DEPTH+1], rand_page());
		wait_replies_drained();
		for (int i = TABLE_DEPTH + 1; i >= 0; i--)
			send_word(CMD_DELETE, name_pool[i], 32'h0);
		wait_replies_drained();
	endtask

	// Random traffic swinging the table between full and empty
	task automatic test_random_mix();
		run_mix(250, 55, 15, 10, 0);
		run_mix(220, 25, 25, 25, 50);
		run_mix(200, 15, 15, 50, 0);
		wait_replies_drained();
	endtask

	// Back-to-back words with neither side idling
	task automatic test_back_to_back();
		idle_on = 1'b0;
		run_mix(160, 35, 20, 20, 0);
		wait_replies_drained();
		idle_on = 1'b1;
	endtask

	initial begin
		mismatch_count = 0;
		words_sent     = 0;
		dir_count      = 0;
		idle_on        = 1'b1;
		for (int i = 0; i < 4; i++)
			status_seen[i] = 0;
		for (int i = 0; i < POOL_SIZE; i++)
			name_pool[i] = (i % 2) ? rand_key() : text_key();
		arst_n = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_fill_and_full();
		test_random_mix();
		test_back_to_back();

		// settle, then report
		s_tvalid <= 1'b0;
		wait (expected_replies.size() == 0);
		repeat (SETTLE_CYC) @(posedge clk);
		$display("ran %0d command words through the directory", words_sent);
		$display("replies: %0d ok, %0d absent, %0d present, %0d full", status_seen[ST_OK],
			status_seen[ST_ABSENT], status_seen[ST_PRESENT], status_seen[ST_FULL]);
		if (mismatch_count == 0 && expected_replies.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/npdt_pkg.sv
src/npdt_ram.sv
src/npdt_datapath.sv
src/npdt_ctrl.sv
src/name_to_page_directory_table_unit.sv
tb/name_to_page_directory_table_unit_tb.sv
